FILE: rtl/mtf_pkg.sv
`default_nettype none
package mtf_pkg;
  localparam int MaxDim = 64;
  localparam int MaxLevels = 7;
  localparam int TexelBits = 48;
  localparam int CoordBits = 16;
  localparam int StoreDepth = (MaxDim * MaxDim * 4) / 3 + MaxLevels;
  localparam int AddrBits = 13;
  localparam int DimBits = 7;

  localparam logic [2:0] RegBaseWidth = 3'd0;
  localparam logic [2:0] RegBaseHeight = 3'd1;
  localparam logic [2:0] RegLevelCount = 3'd2;
  localparam logic [2:0] RegModeU = 3'd3;
  localparam logic [2:0] RegModeV = 3'd4;

  localparam logic [2:0] ModeWrap = 3'd0;
  localparam logic [2:0] ModeClamp = 3'd1;
  localparam logic [2:0] ModeMirror = 3'd2;
  localparam logic [2:0] ModeZero = 3'd3;
  localparam logic [2:0] ModeOne = 3'd4;

  localparam logic [1:0] SrcStore = 2'd0;
  localparam logic [1:0] SrcZero = 2'd1;
  localparam logic [1:0] SrcOne = 2'd2;

  typedef struct packed {
    logic                        is_load;
    logic [TexelBits-1:0]        data;
    logic [2:0]                  level;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } req_t;

  typedef enum logic [2:0] {
    StIdle, StGeom, StModX, StModY, StRead, StOut
  } back_state_e;

  function automatic logic [DimBits-1:0] dim_eff(input logic [DimBits-1:0] v);
    if (v == '0) return DimBits'(1);
    if (32'(v) > MaxDim) return DimBits'(MaxDim);
    return v;
  endfunction

  function automatic logic [DimBits-1:0] halve(input logic [DimBits-1:0] v);
    if (v <= DimBits'(1)) return DimBits'(1);
    return v >> 1;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/mtf_front.sv
`default_nettype none
module mtf_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mtf_pkg::req_t in_req_i,
  output logic               q_valid_o,
  input  wire logic          q_ready_i,
  output mtf_pkg::req_t      q_req_o
);
  import mtf_pkg::*;

  req_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign in_ready_o = cnt_q != 2'd2;
  assign q_valid_o  = cnt_q != 2'd0;
  assign q_req_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) mem_q[wr_q] <= in_req_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) wr_q <= ~wr_q;
      if (q_valid_o && q_ready_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(in_valid_i && in_ready_o) - 2'(q_valid_o && q_ready_i);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/mtf_back.sv
`default_nettype none
module mtf_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         q_valid_i,
  output logic                              q_ready_o,
  input  wire mtf_pkg::req_t                q_req_i,
  input  wire logic [mtf_pkg::DimBits-1:0]  base_width_i,
  input  wire logic [mtf_pkg::DimBits-1:0]  base_height_i,
  input  wire logic [2:0]                   level_count_i,
  input  wire logic [2:0]                   mode_u_i,
  input  wire logic [2:0]                   mode_v_i,
  input  wire logic                         ptr_clear_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [mtf_pkg::TexelBits-1:0]     texel_value_o,
  output logic [1:0]                        texel_source_o
);
  import mtf_pkg::*;

  localparam int ModBits = CoordBits + 1;
  localparam int ShBits = ModBits + DimBits;

  back_state_e state_q, state_d;
  req_t        req_q;
  logic [AddrBits-1:0] ptr_q, off_q, tot_d, idx_q;
  logic [DimBits-1:0]  w_q, h_q;
  logic [2:0]          nlev;
  logic [ModBits-1:0]  rem_q;
  logic [ModBits-1:0]  xr_q;
  logic [4:0]          step_q;
  logic [1:0]          src_q, fsrc_q;
  logic [TexelBits-1:0] rd_q, val_q;
  logic                out_v_q;
  logic [TexelBits-1:0] mem [StoreDepth];

  assign nlev = (level_count_i == 3'd0) ? 3'd1 :
                (32'(level_count_i) > MaxLevels) ? 3'(MaxLevels) : level_count_i;

  // Pyramid size for the load bound, summed over at most seven levels of narrow values.
  always_comb begin
    logic [DimBits-1:0] cw, ch;
    cw = dim_eff(base_width_i);
    ch = dim_eff(base_height_i);
    tot_d = '0;
    for (int i = 0; i < MaxLevels; i++) begin
      if (3'(i) < nlev) begin
        tot_d = tot_d + AddrBits'(cw * ch);
        cw = halve(cw);
        ch = halve(ch);
      end
    end
  end

  assign q_ready_o = state_q == StIdle;
  assign out_valid_o = out_v_q;
  assign texel_value_o = val_q;
  assign texel_source_o = src_q;

  // Mirror period or wrap period of the axis now being resolved.
  logic [2:0]         mode_c;
  logic [DimBits-1:0] n_c;
  logic signed [CoordBits-1:0] c_c;
  logic [ModBits:0]   period;
  logic [ShBits-1:0]  div_sh;
  logic               in_rng;
  assign mode_c = (state_q == StModX) ? mode_u_i : mode_v_i;
  assign n_c    = (state_q == StModX) ? w_q : h_q;
  assign c_c    = (state_q == StModX) ? req_q.x : req_q.y;
  assign period = (mode_c == ModeMirror) ? (ModBits+1)'({n_c, 1'b0}) : (ModBits+1)'(n_c);
  assign div_sh = ShBits'(period) << step_q[3:0];
  assign in_rng = !c_c[CoordBits-1] && (32'(c_c) < 32'(n_c));

  function automatic logic [ModBits-1:0] finish(
    input logic [ModBits-1:0] r, input logic [2:0] m, input logic [DimBits-1:0] n,
    input logic signed [CoordBits-1:0] c, input logic neg, input logic [ModBits:0] p);
    logic [ModBits-1:0] t;
    t = r;
    if (neg && t != '0) t = ModBits'(p) - t;
    if (m == ModeMirror && t >= ModBits'(n)) t = ModBits'({n, 1'b0}) - t - 1'b1;
    if (m != ModeWrap && m != ModeMirror) begin
      if (c[CoordBits-1]) t = '0;
      else t = ModBits'(n) - 1'b1;
    end
    return t;
  endfunction

  logic [ModBits-1:0] sub_r, fin;
  assign sub_r = (ShBits'(rem_q) >= div_sh) ? ModBits'(ShBits'(rem_q) - div_sh) : rem_q;
  assign fin = in_rng ? ModBits'(unsigned'(c_c)) :
               finish(rem_q, mode_c, n_c, c_c, c_c[CoordBits-1], period);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (q_valid_i) state_d = q_req_i.is_load ? StIdle : StGeom;
      StGeom: if (step_q == 5'd0) state_d = StModX;
      StModX: begin
        if (in_rng || mode_c == ModeZero || mode_c == ModeOne) begin
          state_d = (in_rng) ? StModY : StOut;
        end else if (step_q == 5'd31) state_d = StModY;
      end
      StModY: begin
        if (in_rng || mode_c == ModeZero || mode_c == ModeOne) begin
          state_d = in_rng ? StRead : StOut;
        end else if (step_q == 5'd31) state_d = StRead;
      end
      StRead: state_d = StOut;
      StOut: if (!out_v_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && q_valid_i && q_req_i.is_load && 32'(ptr_q) < 32'(tot_d) &&
        32'(ptr_q) < StoreDepth)
      mem[ptr_q] <= q_req_i.data;
    rd_q <= mem[idx_q];
  end

  // Step counter: 16 down to 0 runs restoring reduction, 31 marks finished.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ptr_q <= '0;
      out_v_q <= 1'b0;
      step_q <= '0;
      src_q <= SrcStore;
      fsrc_q <= SrcStore;
      val_q <= '0;
      req_q <= '0;
      w_q <= '0; h_q <= '0; off_q <= '0; rem_q <= '0; xr_q <= '0; idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_v_q && out_ready_i && state_q != StOut) out_v_q <= 1'b0;
      if (ptr_clear_i) ptr_q <= '0;
      unique case (state_q)
        StIdle: if (q_valid_i) begin
          req_q <= q_req_i;
          if (q_req_i.is_load) begin
            if (!ptr_clear_i && 32'(ptr_q) < 32'(tot_d) && 32'(ptr_q) < StoreDepth)
              ptr_q <= ptr_q + 1'b1;
          end else begin
            w_q <= dim_eff(base_width_i);
            h_q <= dim_eff(base_height_i);
            off_q <= '0;
            step_q <= 5'(q_req_i.level > nlev - 3'd1 ? nlev - 3'd1 : q_req_i.level);
          end
        end
        StGeom: begin
          if (step_q != 5'd0) begin
            off_q <= off_q + AddrBits'(w_q * h_q);
            w_q <= halve(w_q);
            h_q <= halve(h_q);
            step_q <= step_q - 1'b1;
          end else begin
            step_q <= 5'd16;
            rem_q <= req_q.x[CoordBits-1] ? ModBits'(-(ModBits'(req_q.x)))
                                          : ModBits'(unsigned'(req_q.x));
          end
        end
        StModX, StModY: begin
          if (in_rng || mode_c == ModeZero || mode_c == ModeOne) begin
            fsrc_q <= in_rng ? SrcStore : (mode_c == ModeZero ? SrcZero : SrcOne);
            if (state_q == StModX) xr_q <= fin;
            else idx_q <= off_q + AddrBits'(fin * ModBits'(w_q)) + AddrBits'(xr_q);
            step_q <= 5'd16;
            rem_q <= req_q.y[CoordBits-1] ? ModBits'(-(ModBits'(req_q.y)))
                                          : ModBits'(unsigned'(req_q.y));
          end else if (step_q == 5'd31) begin
            fsrc_q <= SrcStore;
            if (state_q == StModX) xr_q <= fin;
            else idx_q <= off_q + AddrBits'(fin * ModBits'(w_q)) + AddrBits'(xr_q);
            step_q <= 5'd16;
            rem_q <= req_q.y[CoordBits-1] ? ModBits'(-(ModBits'(req_q.y)))
                                          : ModBits'(unsigned'(req_q.y));
          end else begin
            rem_q <= sub_r;
            step_q <= (step_q == 5'd0) ? 5'd31 : step_q - 1'b1;
          end
        end
        StRead: ;
        StOut: if (!out_v_q || out_ready_i) begin
          out_v_q <= 1'b1;
          src_q <= fsrc_q;
          val_q <= (fsrc_q == SrcStore) ? rd_q : (fsrc_q == SrcOne) ? '1 : '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/mipmap_texel_fetch_address_modes.sv
// Mip-mapped texel fetch with per-axis wrap, clamp, mirror and border modes.
// Input channel (in_valid_i/in_ready_o): req_type_i 0 loads texel_data_i at
// the next store slot, level 0 row-major then each halved level; 1 fetches
// the texel at coord_x_i, coord_y_i of level_i.
// Output channel (out_valid_o/out_ready_i) carries one item per fetch:
// texel_value_o and texel_source_o. Loads give no item.
// Configuration (cfg_valid_i/cfg_ready_o) writes register cfg_index_i; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Geometry writes rewind the load slot. A two-entry queue
// sits between the front and the back. A fetch passes the queue, walks the
// level offsets, then per out-of-range axis in wrap, clamp or mirror mode runs
// a restoring modulo unit, one bit per cycle, then a store read and output; an
// axis out of range in zero or one mode goes straight to output.
// When the receiver stalls, the result is held; the back finishes at most one
// more fetch and waits, the queue then fills and in_ready_o drops.
// Reset restores the register defaults and the load slot; the store
// contents are undefined until loaded.
`default_nettype none
module mipmap_texel_fetch_address_modes (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  req_type_i,
  input  wire logic [2:0]            level_i,
  input  wire logic signed [15:0]    coord_x_i,
  input  wire logic signed [15:0]    coord_y_i,
  input  wire logic [47:0]           texel_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [47:0]                texel_value_o,
  output logic [1:0]                 texel_source_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [6:0]            cfg_data_i
);
  import mtf_pkg::*;

  logic [6:0] bw_q, bh_q;
  logic [2:0] lc_q, mu_q, mv_q;
  logic       clr;
  logic       qv, qr;
  req_t       in_req, q_req;

  assign cfg_ready_o = 1'b1;
  assign clr = cfg_valid_i && (cfg_index_i == RegBaseWidth || cfg_index_i == RegBaseHeight ||
                               cfg_index_i == RegLevelCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q <= 7'd64; bh_q <= 7'd64; lc_q <= 3'd7; mu_q <= ModeWrap; mv_q <= ModeWrap;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegBaseWidth: bw_q <= cfg_data_i;
        RegBaseHeight: bh_q <= cfg_data_i;
        RegLevelCount: lc_q <= cfg_data_i[2:0];
        RegModeU: mu_q <= cfg_data_i[2:0];
        RegModeV: mv_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign in_req = '{is_load: !req_type_i, data: texel_data_i, level: level_i,
                    x: coord_x_i, y: coord_y_i};

  mtf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i(in_req),
    .q_valid_o(qv), .q_ready_i(qr), .q_req_o(q_req)
  );

  mtf_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_ready_o(qr), .q_req_i(q_req),
    .base_width_i(bw_q), .base_height_i(bh_q), .level_count_i(lc_q),
    .mode_u_i(mu_q), .mode_v_i(mv_q), .ptr_clear_i(clr),
    .out_valid_o, .out_ready_i, .texel_value_o, .texel_source_o
  );
endmodule
`default_nettype wire
